/* rtl/cabn_pkg.sv */
// ----------------------------------------------------------------------------
// cabn_pkg - shared types and constants for class-aware box NMS
// Sizes, register codes, box store entry and sequencer states.
// ----------------------------------------------------------------------------
package cabn_pkg;

  localparam int MAX_BOXES  = 64;
  localparam int COORD_BITS = 12;

  localparam int IDX_W   = $clog2(MAX_BOXES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int CLS_W   = 5;
  localparam int SCORE_W = 16;
  localparam int TAG_W   = 8;
  localparam int THR_W   = 17;
  localparam int EXT_W   = COORD_BITS + 1;
  localparam int AREA_W  = 2 * EXT_W;
  localparam int DEN_W   = AREA_W + 1;
  localparam int PROD_W  = DEN_W + THR_W;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SAME_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_THR = 2'd1;

  localparam logic [THR_W-1:0] SAME_THR_RESET  = 17'd39322;
  localparam logic [THR_W-1:0] CROSS_THR_RESET = 17'd64225;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [CLS_W-1:0]   cls;
    logic [SCORE_W-1:0] score;
    coord_t             left;
    coord_t             top;
    coord_t             right;
    coord_t             bottom;
    logic [TAG_W-1:0]   tag;
    logic [AREA_W-1:0]  area;
  } box_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AREA,
    S_AREA_W,
    S_INS_RD,
    S_INS_CMP,
    S_SUP_I,
    S_SUP_ILD,
    S_SUP_J,
    S_OVL,
    S_INTER,
    S_DEN,
    S_CMP,
    S_EM_SCAN,
    S_EM_LD,
    S_EM_WAIT
  } state_t;

  // inclusive pixel extent, clamped at zero
  function automatic logic [EXT_W-1:0] extent(input coord_t lo, input coord_t hi);
    logic [EXT_W-1:0] d;
    d = {1'b0, hi} - {1'b0, lo} + {{(EXT_W-1){1'b0}}, 1'b1};
    return (hi >= lo) ? d : '0;
  endfunction

endpackage

/* rtl/cabn_mul.sv */
// ----------------------------------------------------------------------------
// cabn_mul - shared multiplier
// Unsigned product with a registered output.
// ----------------------------------------------------------------------------
module cabn_mul (
  input  logic                         clk,
  input  logic [cabn_pkg::DEN_W-1:0]   a,
  input  logic [cabn_pkg::THR_W-1:0]   b,
  output logic [cabn_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= cabn_pkg::PROD_W'(a) * cabn_pkg::PROD_W'(b);
  end

endmodule

/* rtl/cabn_store.sv */
// ----------------------------------------------------------------------------
// cabn_store - box store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cabn_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [cabn_pkg::IDX_W-1:0] waddr,
  input  cabn_pkg::box_t             wdata,
  input  logic [cabn_pkg::IDX_W-1:0] raddr,
  output cabn_pkg::box_t             rdata
);

  cabn_pkg::box_t mem [cabn_pkg::MAX_BOXES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/class_aware_box_nms.sv */
// ----------------------------------------------------------------------------
// class_aware_box_nms - class-aware greedy non-maximum suppression
// Loads a set of boxes sorted by score, suppresses overlaps, emits survivors.
// ----------------------------------------------------------------------------
// Boxes are taken one beat at a time and kept in a 64-entry store sorted by
// descending score (ties keep arrival order). Loading a box slides each stored
// box with a lower score up one place, one entry at a time through the read
// and write ports of the store.
// A box arriving with the store full is dropped and flags overflowed on every
// result of its set. The beat with last_box high starts suppression: each box
// is checked against the earlier kept boxes, until one suppresses it, with one
// shared multiplier. Survivors then leave in score order; kept_last marks the
// final one.
// in_ready is high only while the block is idle.
// ----------------------------------------------------------------------------
module class_aware_box_nms (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [cabn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cabn_pkg::THR_W-1:0]      cfg_data,
  // box input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cabn_pkg::CLS_W-1:0]      class_code,
  input  logic [cabn_pkg::SCORE_W-1:0]    score,
  input  logic [cabn_pkg::COORD_BITS-1:0] left_edge,
  input  logic [cabn_pkg::COORD_BITS-1:0] top_edge,
  input  logic [cabn_pkg::COORD_BITS-1:0] right_edge,
  input  logic [cabn_pkg::COORD_BITS-1:0] bottom_edge,
  input  logic [cabn_pkg::TAG_W-1:0]      source_order,
  input  logic                            last_box,
  // survivor output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cabn_pkg::CLS_W-1:0]      kept_class,
  output logic [cabn_pkg::SCORE_W-1:0]    kept_score,
  output logic [cabn_pkg::COORD_BITS-1:0] kept_left,
  output logic [cabn_pkg::COORD_BITS-1:0] kept_top,
  output logic [cabn_pkg::COORD_BITS-1:0] kept_right,
  output logic [cabn_pkg::COORD_BITS-1:0] kept_bottom,
  output logic [cabn_pkg::TAG_W-1:0]      kept_order,
  output logic                            kept_last,
  output logic                            overflowed
);

  cabn_pkg::state_t state, state_next;

  // thresholds
  logic [cabn_pkg::THR_W-1:0] same_thr, cross_thr;

  // set control
  logic [cabn_pkg::CNT_W-1:0]     count;
  logic                           ovf;
  logic                           last_q;
  logic [cabn_pkg::MAX_BOXES-1:0] kept;
  logic [cabn_pkg::IDX_W-1:0]     pos, i, j, e;

  // datapath registers
  cabn_pkg::box_t              cur;      // box being loaded, then box i
  cabn_pkg::box_t              out_box;
  logic [cabn_pkg::AREA_W-1:0] aj;
  logic [cabn_pkg::AREA_W-1:0] inter;
  logic [cabn_pkg::THR_W-1:0]  thr_q;
  logic                        den_zero;

  // store and multiplier hookup
  logic                        st_we;
  logic [cabn_pkg::IDX_W-1:0]  st_waddr, st_raddr;
  cabn_pkg::box_t              st_wdata, st_rdata;
  logic [cabn_pkg::DEN_W-1:0]  mul_a;
  logic [cabn_pkg::THR_W-1:0]  mul_b;
  logic [cabn_pkg::PROD_W-1:0] prod;

  // combinational helpers
  logic                           full, in_fire, out_fire;
  logic                           shift_up, ins_done, last_i, reach, none_above;
  logic [cabn_pkg::DEN_W-1:0]     denom;
  logic [cabn_pkg::MAX_BOXES-1:0] above;
  cabn_pkg::coord_t               ol, ot, orr, ob;

  cabn_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  cabn_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign full     = (count == cabn_pkg::CNT_W'(cabn_pkg::MAX_BOXES));
  assign in_ready = (state == cabn_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // insertion: slide the lower-scored entry up one place
  assign shift_up = (st_rdata.score < cur.score);
  assign ins_done = ((state == cabn_pkg::S_INS_RD) && (pos == '0)) ||
                    ((state == cabn_pkg::S_INS_CMP) && !shift_up);

  assign last_i = (({1'b0, i} + cabn_pkg::CNT_W'(1)) == count);

  // overlap rectangle of box i (cur) and box j (read data)
  assign ol  = (cur.left  > st_rdata.left)   ? cur.left   : st_rdata.left;
  assign ot  = (cur.top   > st_rdata.top)    ? cur.top    : st_rdata.top;
  assign orr = (cur.right < st_rdata.right)  ? cur.right  : st_rdata.right;
  assign ob  = (cur.bottom < st_rdata.bottom) ? cur.bottom : st_rdata.bottom;

  assign denom = cabn_pkg::DEN_W'(cur.area) + cabn_pkg::DEN_W'(aj) -
                 cabn_pkg::DEN_W'(inter);

  // inter * 2^16 >= thr * denom; zero denominator reaches only a zero threshold
  assign reach = den_zero ? (thr_q == '0) :
                 (cabn_pkg::PROD_W'({inter, 16'h0}) >= prod);

  assign above      = kept >> e;
  assign none_above = (above[cabn_pkg::MAX_BOXES-1:1] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cabn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    st_we      = 1'b0;
    st_waddr   = pos;
    st_wdata   = cur;
    st_raddr   = '0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      cabn_pkg::S_IDLE: begin
        if (in_fire) begin
          if (!full) begin
            state_next = cabn_pkg::S_AREA;
          end else if (last_box) begin
            state_next = cabn_pkg::S_SUP_I;
          end
        end
      end
      cabn_pkg::S_AREA: begin
        mul_a      = cabn_pkg::DEN_W'(cabn_pkg::extent(cur.left, cur.right));
        mul_b      = cabn_pkg::THR_W'(cabn_pkg::extent(cur.top, cur.bottom));
        state_next = cabn_pkg::S_AREA_W;
      end
      cabn_pkg::S_AREA_W: begin
        state_next = cabn_pkg::S_INS_RD;
      end
      cabn_pkg::S_INS_RD: begin
        st_raddr = pos - cabn_pkg::IDX_W'(1);
        if (pos == '0) begin
          st_we      = 1'b1;
          state_next = last_q ? cabn_pkg::S_SUP_I : cabn_pkg::S_IDLE;
        end else begin
          state_next = cabn_pkg::S_INS_CMP;
        end
      end
      cabn_pkg::S_INS_CMP: begin
        st_we = 1'b1;
        if (shift_up) begin
          st_wdata   = st_rdata;
          state_next = cabn_pkg::S_INS_RD;
        end else begin
          state_next = last_q ? cabn_pkg::S_SUP_I : cabn_pkg::S_IDLE;
        end
      end
      cabn_pkg::S_SUP_I: begin
        st_raddr   = i;
        state_next = cabn_pkg::S_SUP_ILD;
      end
      cabn_pkg::S_SUP_ILD: begin
        state_next = cabn_pkg::S_SUP_J;
      end
      cabn_pkg::S_SUP_J: begin
        st_raddr = j;
        if (j == i) begin
          state_next = last_i ? cabn_pkg::S_EM_SCAN : cabn_pkg::S_SUP_I;
        end else if (kept[j]) begin
          state_next = cabn_pkg::S_OVL;
        end
      end
      cabn_pkg::S_OVL: begin
        mul_a      = cabn_pkg::DEN_W'(cabn_pkg::extent(ol, orr));
        mul_b      = cabn_pkg::THR_W'(cabn_pkg::extent(ot, ob));
        state_next = cabn_pkg::S_INTER;
      end
      cabn_pkg::S_INTER: begin
        state_next = cabn_pkg::S_DEN;
      end
      cabn_pkg::S_DEN: begin
        mul_a      = denom;
        mul_b      = thr_q;
        state_next = cabn_pkg::S_CMP;
      end
      cabn_pkg::S_CMP: begin
        if (reach) begin
          state_next = last_i ? cabn_pkg::S_EM_SCAN : cabn_pkg::S_SUP_I;
        end else begin
          state_next = cabn_pkg::S_SUP_J;
        end
      end
      cabn_pkg::S_EM_SCAN: begin
        st_raddr = e;
        if (kept[e]) begin
          state_next = cabn_pkg::S_EM_LD;
        end
      end
      cabn_pkg::S_EM_LD: begin
        state_next = cabn_pkg::S_EM_WAIT;
      end
      cabn_pkg::S_EM_WAIT: begin
        if (out_ready) begin
          state_next = kept_last ? cabn_pkg::S_IDLE : cabn_pkg::S_EM_SCAN;
        end
      end
      default: begin
        state_next = cabn_pkg::S_IDLE;
      end
    endcase
  end

  // thresholds
  always_ff @(posedge clk) begin
    if (rst) begin
      same_thr  <= cabn_pkg::SAME_THR_RESET;
      cross_thr <= cabn_pkg::CROSS_THR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == cabn_pkg::REG_SAME_THR) begin
        same_thr <= cfg_data;
      end
      if (cfg_index == cabn_pkg::REG_CROSS_THR) begin
        cross_thr <= cfg_data;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      kept      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire && full) begin
        ovf <= 1'b1;
      end
      if (ins_done) begin
        count <= count + cabn_pkg::CNT_W'(1);
      end
      if ((state == cabn_pkg::S_SUP_J) && (j == i)) begin
        kept[i] <= 1'b1;
      end
      if (state == cabn_pkg::S_EM_LD) begin
        out_valid <= 1'b1;
      end
      if ((state == cabn_pkg::S_EM_WAIT) && out_fire) begin
        out_valid <= 1'b0;
        if (kept_last) begin
          count <= '0;
          ovf   <= 1'b0;
          kept  <= '0;
        end
      end
    end
  end

  // indices and datapath
  always_ff @(posedge clk) begin
    case (state)
      cabn_pkg::S_IDLE: begin
        cur.cls    <= class_code;
        cur.score  <= score;
        cur.left   <= left_edge;
        cur.top    <= top_edge;
        cur.right  <= right_edge;
        cur.bottom <= bottom_edge;
        cur.tag    <= source_order;
        last_q     <= last_box;
        i          <= '0;
      end
      cabn_pkg::S_AREA_W: begin
        cur.area <= prod[cabn_pkg::AREA_W-1:0];
        pos      <= count[cabn_pkg::IDX_W-1:0];
      end
      cabn_pkg::S_INS_CMP: begin
        if (shift_up) begin
          pos <= pos - cabn_pkg::IDX_W'(1);
        end
      end
      cabn_pkg::S_SUP_ILD: begin
        cur <= st_rdata;
        j   <= '0;
      end
      cabn_pkg::S_SUP_J: begin
        if (j == i) begin
          i <= i + cabn_pkg::IDX_W'(1);
          e <= '0;
        end else if (!kept[j]) begin
          j <= j + cabn_pkg::IDX_W'(1);
        end
      end
      cabn_pkg::S_OVL: begin
        aj    <= st_rdata.area;
        thr_q <= (st_rdata.cls == cur.cls) ? same_thr : cross_thr;
      end
      cabn_pkg::S_INTER: begin
        inter <= prod[cabn_pkg::AREA_W-1:0];
      end
      cabn_pkg::S_DEN: begin
        den_zero <= (denom == '0);
      end
      cabn_pkg::S_CMP: begin
        if (reach) begin
          i <= i + cabn_pkg::IDX_W'(1);
          e <= '0;
        end else begin
          j <= j + cabn_pkg::IDX_W'(1);
        end
      end
      cabn_pkg::S_EM_SCAN: begin
        if (!kept[e]) begin
          e <= e + cabn_pkg::IDX_W'(1);
        end
      end
      cabn_pkg::S_EM_LD: begin
        out_box    <= st_rdata;
        kept_last  <= none_above;
        overflowed <= ovf;
      end
      cabn_pkg::S_EM_WAIT: begin
        if (out_ready) begin
          e <= e + cabn_pkg::IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign kept_class  = out_box.cls;
  assign kept_score  = out_box.score;
  assign kept_left   = out_box.left;
  assign kept_top    = out_box.top;
  assign kept_right  = out_box.right;
  assign kept_bottom = out_box.bottom;
  assign kept_order  = out_box.tag;

endmodule

/* rtl/cabn_checker.sv */
// ----------------------------------------------------------------------------
// cabn_checker - port-level assertions for class_aware_box_nms
// Watches the handshakes and set boundaries seen on the top-level ports.
// ----------------------------------------------------------------------------
module cabn_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         kept_last,
  input logic [cabn_pkg::SCORE_W-1:0] kept_score
);

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready high while a result beat is offered");

  // the final survivor ends the output burst
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && kept_last) |=> !out_valid)
    else $error("out_valid after the last beat of a set");

  // mid-burst the block stays busy
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !kept_last) |=> !in_ready)
    else $error("input opened before the set was fully emitted");

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(kept_score)))
    else $error("stalled result beat changed");

endmodule

bind class_aware_box_nms cabn_checker u_cabn_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .kept_last  (kept_last),
  .kept_score (kept_score)
);
